// ----- rtl/core/lda_collapsed_gibbs_token_update_assert.svh -----
// assertion macros for the lda token update block
// expects signals clk and arst_n in the including module
`ifndef LDA_COLLAPSED_GIBBS_TOKEN_UPDATE_ASSERT_SVH
`define LDA_COLLAPSED_GIBBS_TOKEN_UPDATE_ASSERT_SVH

// same-cycle implication
`define LGS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lgs assertion failed");

// next-cycle implication
`define LGS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lgs assertion failed");

`endif

// ----- rtl/core/lgs_pkg.sv -----
// shared types and constants for the lda token update block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lgs_pkg;
	localparam int MAX_TOPICS = 64;
	localparam int MAX_DOCS   = 1024;
	localparam int VOCAB_SIZE = 4096;
	localparam int COUNT_W    = 24;
	localparam int FRAC_W     = 16;
	localparam int TOPIC_W    = $clog2(MAX_TOPICS);
	localparam int DOC_W      = $clog2(MAX_DOCS);
	localparam int WORD_W     = $clog2(VOCAB_SIZE);
	localparam int DT_AW      = DOC_W + TOPIC_W;
	localparam int WT_AW      = WORD_W + TOPIC_W;
	localparam int PROD_W     = 96;
	localparam int OPND_W     = 48;
	localparam int WEIGHT_W   = 42;
	localparam int PREFIX_W   = 48;
	localparam int DIVR_W     = 42;
	localparam int STEP_W     = 6;
	localparam int MUL_STEPS  = 48;
	localparam int DIV_STEPS  = 42;

	localparam logic [23:0] ALPHA_RST  = 24'd655;
	localparam logic [23:0] BETA_RST   = 24'd3277;
	localparam logic [12:0] VOCAB_RST  = 13'd4096;
	localparam logic [6:0]  TOPICS_RST = 7'd64;

	localparam logic [1:0] REG_ALPHA  = 2'd0;
	localparam logic [1:0] REG_BETA   = 2'd1;
	localparam logic [1:0] REG_VOCAB  = 2'd2;
	localparam logic [1:0] REG_TOPICS = 2'd3;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_LOAD   = 1'b1;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} lgs_op_t;

	typedef struct packed {
		logic    start;
		lgs_op_t op;
	} lgs_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lgs_stat_t;
endpackage
`default_nettype wire

// ----- rtl/core/lgs_muldiv.sv -----
// bit-serial multiply and saturating restoring divide on one shared adder
// depends on lgs_pkg
`timescale 1ns / 1ps
`default_nettype none
module lgs_muldiv import lgs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  lgs_cmd_t            cmd,
	input  logic [PROD_W-1:0]   opnd_a,
	input  logic [OPND_W-1:0]   opnd_b,
	output lgs_stat_t           stat,
	output logic [PROD_W-1:0]   product,
	output logic [WEIGHT_W-1:0] quotient
);
	localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_STEPS - 1);
	localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

	logic              busy_q, done_q, pre_q, sat_q;
	lgs_op_t           op_q;
	logic [STEP_W-1:0] cnt_q;
	logic [PROD_W-1:0] p_q;
	logic [OPND_W-1:0] mc_q;

	logic [OPND_W-1:0] rem2;
	logic [OPND_W:0]   add_a, add_b;
	logic [OPND_W+1:0] sum;
	logic              geq;

	// shifted partial remainder for a divide step
	assign rem2 = {p_q[PROD_W-2:OPND_W], p_q[OPND_W-1]};

	always_comb begin
		if (op_q == OP_MUL) begin
			add_a = {1'b0, p_q[PROD_W-1:OPND_W]};
			add_b = {1'b0, mc_q};
		end else begin
			add_a = pre_q ? {1'b0, p_q[PROD_W-1:OPND_W]} : {1'b0, rem2};
			add_b = ~{1'b0, mc_q};
		end
		sum = {1'b0, add_a} + {1'b0, add_b} + {{(OPND_W+1){1'b0}}, (op_q == OP_DIV)};
	end
	assign geq = sum[OPND_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pre_q  <= 1'b0;
			sat_q  <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= cmd.op;
				pre_q  <= (cmd.op == OP_DIV);
				sat_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (op_q == OP_DIV && pre_q) begin
					// quotient would not fit, or zero divisor
					pre_q <= 1'b0;
					sat_q <= geq;
					if (geq) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ((op_q == OP_MUL) ? MUL_LAST : DIV_LAST)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && !busy_q) begin
			mc_q <= opnd_b;
			if (cmd.op == OP_MUL)
				p_q <= {{(PROD_W-OPND_W){1'b0}}, opnd_a[OPND_W-1:0]};
			else
				p_q <= {8'b0, opnd_a[81:42], opnd_a[41:0], 6'b0};
		end else if (busy_q && !(op_q == OP_DIV && pre_q)) begin
			if (op_q == OP_MUL) begin
				if (p_q[0])
					p_q <= {sum[OPND_W:0], p_q[OPND_W-1:1]};
				else
					p_q <= {1'b0, p_q[PROD_W-1:1]};
			end else begin
				p_q <= {(geq ? sum[OPND_W-1:0] : rem2), p_q[OPND_W-2:0], geq};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = p_q;
	assign quotient  = sat_q ? {WEIGHT_W{1'b1}} : p_q[WEIGHT_W-1:0];
endmodule
`default_nettype wire

// ----- rtl/core/lda_collapsed_gibbs_token_update.sv -----
// lda collapsed gibbs token update: count tables, topic weights and sampling
// depends on lgs_pkg, lgs_muldiv and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
// After reset the block clears its count tables, one entry a cycle, with
// busy high; configuration words are taken throughout. A word is taken
// when start is high and busy low. A load word passes through S_INC_RD and
// S_INC_WR and then puts its result out. For a sample word every topic
// needs a 48-step multiply and a 43-step divide on the single
// shift-add/subtract unit, one bit a cycle, and the search over the stored
// prefix sums reads and compares one prefix a topic; a sample word ends
// sooner when the search stops early or a divide saturates. The result is
// on new_topic for exactly one cycle with done high and cannot be held off
// by the receiver.
module lda_collapsed_gibbs_token_update import lgs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic          kind,
	input  logic [9:0]    doc_index,
	input  logic [11:0]   word_index,
	input  logic [5:0]    old_topic,
	input  logic [31:0]   uniform_fraction,
	output logic          done,
	output logic [5:0]    new_topic,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [23:0]   cfg_data
);
`include "lda_collapsed_gibbs_token_update_assert.svh"

	typedef enum logic [17:0] {
		S_CLEAR   = 18'h00001,
		S_IDLE    = 18'h00002,
		S_DEC_RD  = 18'h00004,
		S_DEC_WR  = 18'h00008,
		S_BW_MUL  = 18'h00010,
		S_BW_WAIT = 18'h00020,
		S_TK_RD   = 18'h00040,
		S_TK_MUL  = 18'h00080,
		S_TK_MULW = 18'h00100,
		S_TK_DIV  = 18'h00200,
		S_TK_DIVW = 18'h00400,
		S_TK_ACC  = 18'h00800,
		S_THR_MUL = 18'h01000,
		S_THR_WT  = 18'h02000,
		S_SR_RD   = 18'h04000,
		S_SR_CMP  = 18'h08000,
		S_INC_RD  = 18'h10000,
		S_INC_WR  = 18'h20000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [23:0] alpha_q, beta_q;
	logic [12:0] vocab_q;
	logic [6:0]  topics_q;

	// latched word and working registers
	logic               kind_q;
	logic [DOC_W-1:0]   doc_q;
	logic [WORD_W-1:0]  word_q;
	logic [TOPIC_W-1:0] topic_q, k_q, last_q;
	logic [31:0]        u_q;
	logic [36:0]        bw_q;
	logic [DIVR_W-1:0]  d_q;
	logic [PREFIX_W-1:0] total_q, thr_q;
	logic [WT_AW-1:0]   clr_q;
	logic               done_q;

	// count tables and prefix store
	logic [COUNT_W-1:0]  dt_mem [MAX_DOCS*MAX_TOPICS];
	logic [COUNT_W-1:0]  wt_mem [VOCAB_SIZE*MAX_TOPICS];
	logic [COUNT_W-1:0]  tt_mem [MAX_TOPICS];
	logic [PREFIX_W-1:0] wp_mem [MAX_TOPICS];
	logic [COUNT_W-1:0]  dt_rd, wt_rd, tt_rd;
	logic [PREFIX_W-1:0] wp_rd;

	logic [DT_AW-1:0]   dt_addr;
	logic [WT_AW-1:0]   wt_addr;
	logic [TOPIC_W-1:0] tt_addr, tk_sel;
	logic               cnt_we;
	logic [COUNT_W-1:0] dt_wd, wt_wd, tt_wd;

	// shared unit
	lgs_cmd_t            ucmd;
	lgs_stat_t           ustat;
	logic [PROD_W-1:0]   uopa, uprod;
	logic [OPND_W-1:0]   uopb;
	logic [WEIGHT_W-1:0] uquot;

	logic [40:0]         a_val, b_val;
	logic [DIVR_W-1:0]   d_val;
	logic [PREFIX_W:0]   acc_sum;
	logic [PREFIX_W-1:0] total_nx;
	logic                accept;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign new_topic = topic_q;

	// saturating step on a count
	function automatic logic [COUNT_W-1:0] cnt_step(logic [COUNT_W-1:0] c, logic up);
		logic [COUNT_W-1:0] r;
		r = c;
		if (up) begin
			if (c != {COUNT_W{1'b1}})
				r = c + 1'b1;
		end else if (c != '0) begin
			r = c - 1'b1;
		end
		return r;
	endfunction

	// topic loop and count updates share the table ports
	assign tk_sel  = (state_q == S_TK_RD) ? k_q : topic_q;
	assign dt_addr = (state_q == S_CLEAR) ? clr_q[DT_AW-1:0] : {doc_q, tk_sel};
	assign wt_addr = (state_q == S_CLEAR) ? clr_q : {word_q, tk_sel};
	assign tt_addr = (state_q == S_CLEAR) ? clr_q[TOPIC_W-1:0] : tk_sel;
	assign cnt_we  = (state_q == S_CLEAR) || (state_q == S_DEC_WR) || (state_q == S_INC_WR);

	always_comb begin
		if (state_q == S_CLEAR) begin
			dt_wd = '0;
			wt_wd = '0;
			tt_wd = '0;
		end else begin
			dt_wd = cnt_step(dt_rd, state_q == S_INC_WR);
			wt_wd = cnt_step(wt_rd, state_q == S_INC_WR);
			tt_wd = cnt_step(tt_rd, state_q == S_INC_WR);
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			dt_mem[dt_addr] <= dt_wd;
		dt_rd <= dt_mem[dt_addr];
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			wt_mem[wt_addr] <= wt_wd;
		wt_rd <= wt_mem[wt_addr];
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			tt_mem[tt_addr] <= tt_wd;
		tt_rd <= tt_mem[tt_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_TK_ACC)
			wp_mem[k_q] <= total_nx;
		wp_rd <= wp_mem[k_q];
	end

	// weight operands in fixed point, 16 fraction bits
	assign a_val = {1'b0, dt_rd, {FRAC_W{1'b0}}} + {17'b0, alpha_q};
	assign b_val = {1'b0, wt_rd, {FRAC_W{1'b0}}} + {17'b0, beta_q};
	assign d_val = {2'b0, tt_rd, {FRAC_W{1'b0}}} + {5'b0, bw_q};

	// saturating prefix sum
	assign acc_sum  = {1'b0, total_q} + {7'b0, uquot};
	assign total_nx = acc_sum[PREFIX_W] ? {PREFIX_W{1'b1}} : acc_sum[PREFIX_W-1:0];

	always_comb begin
		ucmd.start = (state_q == S_BW_MUL) || (state_q == S_TK_MUL) ||
		             (state_q == S_TK_DIV) || (state_q == S_THR_MUL);
		ucmd.op    = (state_q == S_TK_DIV) ? OP_DIV : OP_MUL;
		case (state_q)
			S_BW_MUL: begin
				uopa = {72'b0, beta_q};
				uopb = {35'b0, vocab_q};
			end
			S_TK_MUL: begin
				uopa = {55'b0, a_val};
				uopb = {7'b0, b_val};
			end
			S_TK_DIV: begin
				uopa = uprod;
				uopb = {6'b0, d_q};
			end
			default: begin
				uopa = {48'b0, total_q};
				uopb = {16'b0, u_q};
			end
		endcase
	end

	lgs_muldiv u_muldiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ucmd),
		.opnd_a   (uopa),
		.opnd_b   (uopb),
		.stat     (ustat),
		.product  (uprod),
		.quotient (uquot)
	);

	// configuration words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= ALPHA_RST;
			beta_q   <= BETA_RST;
			vocab_q  <= VOCAB_RST;
			topics_q <= TOPICS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ALPHA:  alpha_q  <= cfg_data;
				REG_BETA:   beta_q   <= cfg_data;
				REG_VOCAB:  vocab_q  <= cfg_data[12:0];
				REG_TOPICS: topics_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			topic_q <= '0;
			k_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {WT_AW{1'b1}})
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						topic_q <= old_topic;
						k_q     <= '0;
						state_q <= (kind == KIND_LOAD) ? S_INC_RD : S_DEC_RD;
					end
				end
				S_DEC_RD:  state_q <= S_DEC_WR;
				S_DEC_WR:  state_q <= S_BW_MUL;
				S_BW_MUL:  state_q <= S_BW_WAIT;
				S_BW_WAIT: if (ustat.done) state_q <= S_TK_RD;
				S_TK_RD:   state_q <= S_TK_MUL;
				S_TK_MUL:  state_q <= S_TK_MULW;
				S_TK_MULW: if (ustat.done) state_q <= S_TK_DIV;
				S_TK_DIV:  state_q <= S_TK_DIVW;
				S_TK_DIVW: if (ustat.done) state_q <= S_TK_ACC;
				S_TK_ACC: begin
					if (k_q == last_q) begin
						k_q     <= '0;
						state_q <= S_THR_MUL;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_TK_RD;
					end
				end
				S_THR_MUL: state_q <= S_THR_WT;
				S_THR_WT:  if (ustat.done) state_q <= S_SR_RD;
				S_SR_RD:   state_q <= S_SR_CMP;
				S_SR_CMP: begin
					// first prefix above the threshold, else the last topic
					if (wp_rd > thr_q || k_q == last_q) begin
						topic_q <= k_q;
						state_q <= S_INC_RD;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_SR_RD;
					end
				end
				S_INC_RD: state_q <= S_INC_WR;
				S_INC_WR: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind;
			doc_q   <= doc_index;
			word_q  <= word_index;
			u_q     <= uniform_fraction;
			total_q <= '0;
			// topic count clamped to one..max
			if (topics_q == '0)
				last_q <= '0;
			else if (topics_q > 7'(MAX_TOPICS))
				last_q <= TOPIC_W'(MAX_TOPICS - 1);
			else
				last_q <= TOPIC_W'(topics_q - 7'd1);
		end
		if (state_q == S_BW_WAIT && ustat.done)
			bw_q <= uprod[36:0];
		if (state_q == S_TK_MUL)
			d_q <= d_val;
		if (state_q == S_TK_ACC)
			total_q <= total_nx;
		if (state_q == S_THR_WT && ustat.done)
			thr_q <= uprod[79:32];
	end

	`LGS_ASSERT_NEXT(a_done_single, done, !done)
	`LGS_ASSERT_NEXT(a_accept_busy, accept, busy)
	`LGS_ASSERT_IMPL(a_unit_free, ucmd.start, !ustat.busy)
	`LGS_ASSERT_IMPL(a_load_short, done && kind_q == KIND_LOAD, $past(state_q) == S_INC_WR)
endmodule
`default_nettype wire

// ----- tb/lda_collapsed_gibbs_token_update_test.sv -----
// self-checking testbench for the lda collapsed gibbs token update block
// depends on lgs_pkg and lda_collapsed_gibbs_token_update
`timescale 1ns / 1ps
module lda_collapsed_gibbs_token_update_test;
	import lgs_pkg::*;

	localparam logic [41:0] W_SAT = {42{1'b1}};
	localparam logic [47:0] P_SAT = {48{1'b1}};
	localparam int unsigned C_SAT = (1 << COUNT_W) - 1;
	localparam longint LIMIT = 64'd20_000_000;
	localparam int POOL = 24;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t  rk;
		logic       kind;
		logic [9:0] doc;
		logic [11:0] word;
		logic [5:0] old;
		logic [31:0] u;
		logic       typed;
		logic [5:0] topic;
		logic [1:0] idx;
		logic [23:0] data;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        kind = 1'b0;
	logic [9:0]  doc_index = '0;
	logic [11:0] word_index = '0;
	logic [5:0]  old_topic = '0;
	logic [31:0] uniform_fraction = '0;
	logic        done;
	logic [5:0]  new_topic;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	// side channel travelling with each word: fixed expectation and pool slot
	logic        typed_en = 1'b0;
	logic [5:0]  typed_topic = '0;
	int          tok_slot = -1;

	// shadow of the block's registers and count tables
	logic [23:0] sh_alpha = ALPHA_RST;
	logic [23:0] sh_beta = BETA_RST;
	logic [12:0] sh_vocab = VOCAB_RST;
	logic [6:0]  sh_topics = TOPICS_RST;
	int unsigned doc_topic_cnt[int];
	int unsigned word_topic_cnt[int];
	int unsigned topic_total[MAX_TOPICS];

	logic [5:0]  topic_exp_q[$];
	int          errors = 0;
	longint      cycles = 0;

	// token pool for well-formed resampling
	logic [9:0]  pool_doc[POOL];
	logic [11:0] pool_word[POOL];
	logic [5:0]  pool_topic[POOL];

	lda_collapsed_gibbs_token_update u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.doc_index(doc_index), .word_index(word_index), .old_topic(old_topic),
		.uniform_fraction(uniform_fraction), .done(done), .new_topic(new_topic),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic report(input string what, input logic [5:0] got, input logic [5:0] want);
		$display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	function automatic int unsigned dt_get(input int key);
		return doc_topic_cnt.exists(key) ? doc_topic_cnt[key] : 0;
	endfunction

	function automatic int unsigned wt_get(input int key);
		return word_topic_cnt.exists(key) ? word_topic_cnt[key] : 0;
	endfunction

	// add or remove one token; decrements stop at zero, increments at the count limit
	task automatic move_token(input logic [9:0] d, input logic [11:0] w, input logic [5:0] t,
			input bit add);
		int dk;
		int wk;
		int unsigned c;
		dk = d * MAX_TOPICS + t;
		wk = w * MAX_TOPICS + t;
		if (add) begin
			c = dt_get(dk); if (c < C_SAT) doc_topic_cnt[dk] = c + 1;
			c = wt_get(wk); if (c < C_SAT) word_topic_cnt[wk] = c + 1;
			if (topic_total[t] < C_SAT) topic_total[t]++;
		end else begin
			c = dt_get(dk); if (c > 0) doc_topic_cnt[dk] = c - 1;
			c = wt_get(wk); if (c > 0) word_topic_cnt[wk] = c - 1;
			if (topic_total[t] > 0) topic_total[t]--;
		end
	endtask

	// full sample step: remove old topic, weigh topics, pick, add the pick
	task automatic sample_topic(input logic [9:0] d, input logic [11:0] w, input logic [5:0] old,
			input logic [31:0] u, output logic [5:0] pick);
		int kk;
		logic [63:0] a, b, dv, dadd;
		logic [127:0] prod, q;
		logic [41:0] wt;
		logic [48:0] sum;
		logic [47:0] total;
		logic [47:0] prefix[MAX_TOPICS];
		logic [79:0] tu;
		logic [47:0] thr;
		bit found;
		move_token(d, w, old, 1'b0);
		kk = sh_topics;
		if (kk == 0) kk = 1;
		if (kk > MAX_TOPICS) kk = MAX_TOPICS;
		dadd = 64'(sh_beta) * 64'(sh_vocab);
		total = '0;
		for (int k = 0; k < kk; k++) begin
			a = (64'(dt_get(d * MAX_TOPICS + k)) << FRAC_W) + 64'(sh_alpha);
			b = (64'(wt_get(w * MAX_TOPICS + k)) << FRAC_W) + 64'(sh_beta);
			dv = (64'(topic_total[k]) << FRAC_W) + dadd;
			prod = 128'(a) * 128'(b);
			if (dv == 0) begin
				wt = W_SAT;
			end else begin
				q = prod / 128'(dv);
				wt = (q > 128'(W_SAT)) ? W_SAT : q[41:0];
			end
			sum = 49'(total) + 49'(wt);
			total = (sum > 49'(P_SAT)) ? P_SAT : sum[47:0];
			prefix[k] = total;
		end
		tu = 80'(total) * 80'(u);
		thr = tu[79:32];
		pick = 6'(kk - 1);
		found = 0;
		for (int k = 0; k < kk; k++) begin
			if (!found && prefix[k] > thr) begin
				pick = 6'(k);
				found = 1;
			end
		end
		move_token(d, w, pick, 1'b1);
	endtask

	// acceptance monitor: register shadow, prediction and result checking
	always @(posedge clk) begin
		logic [5:0] pick;
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout at cycle %0d", cycles);
			$display("DONE: errors detected");
			$finish;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ALPHA:  sh_alpha = cfg_data;
					REG_BETA:   sh_beta = cfg_data;
					REG_VOCAB:  sh_vocab = cfg_data[12:0];
					REG_TOPICS: sh_topics = cfg_data[6:0];
					default: ;
				endcase
			end
			if (done) begin
				if (topic_exp_q.size() == 0)
					report("unexpected word", new_topic, 6'd0);
				else begin
					logic [5:0] want;
					want = topic_exp_q.pop_front();
					if (new_topic !== want) report("new_topic", new_topic, want);
				end
			end
			if (start && !busy) begin
				if (kind == KIND_LOAD) begin
					move_token(doc_index, word_index, old_topic, 1'b1);
					pick = old_topic;
				end else
					sample_topic(doc_index, word_index, old_topic, uniform_fraction, pick);
				topic_exp_q.push_back(typed_en ? typed_topic : pick);
				if (tok_slot >= 0) pool_topic[tok_slot] = pick;
			end
		end
	end

	// idle gap after a word: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(80, 20);
	endfunction

	task automatic send_word(input logic k, input logic [9:0] d, input logic [11:0] w,
			input logic [5:0] t, input logic [31:0] u, input logic ten, input logic [5:0] tv,
			input int slot);
		int gap;
		start <= 1'b1;
		kind <= k;
		doc_index <= d;
		word_index <= w;
		old_topic <= t;
		uniform_fraction <= u;
		typed_en <= ten;
		typed_topic <= tv;
		tok_slot <= slot;
		do @(negedge clk); while (busy);
		@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// register writes only once every expected word is back
	task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
		if (start) begin
			start <= 1'b0;
			@(posedge clk);
		end
		while (topic_exp_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic stim_row_t item(input logic k, input logic [9:0] d, input logic [11:0] w,
			input logic [5:0] t, input logic [31:0] u, input logic ten, input logic [5:0] tv);
		stim_row_t r;
		r = '{rk: ROW_WORD, kind: k, doc: d, word: w, old: t, u: u, typed: ten, topic: tv,
			idx: REG_ALPHA, data: '0};
		return r;
	endfunction

	function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [23:0] data);
		stim_row_t r;
		r = '{rk: ROW_CFG, kind: KIND_LOAD, doc: '0, word: '0, old: '0, u: '0, typed: 1'b0,
			topic: '0, idx: idx, data: data};
		return r;
	endfunction

	stim_row_t dir_tab[$];

	initial begin
		int nsamp;
		int s;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		dir_tab = '{
			reg_row(REG_TOPICS, 24'd4),
			item(KIND_LOAD, 10'd0, 12'd0, 6'd3, 32'd0, 1'b1, 6'd3),
			// loaded topic above the topics in use, still echoed
			item(KIND_LOAD, 10'd1023, 12'd4095, 6'd63, 32'd0, 1'b1, 6'd63),
			item(KIND_LOAD, 10'd0, 12'd0, 6'd3, 32'hFFFF_FFFF, 1'b1, 6'd3),
			item(KIND_SAMPLE, 10'd0, 12'd0, 6'd3, 32'd0, 1'b0, 6'd0),
			// old topic at or above K is still removed
			item(KIND_SAMPLE, 10'd1023, 12'd4095, 6'd63, 32'hFFFF_FFFF, 1'b0, 6'd0),
			item(KIND_SAMPLE, 10'd0, 12'd0, 6'd60, 32'h8000_0000, 1'b0, 6'd0),
			// no prior and an empty document: every weight zero, last topic
			reg_row(REG_ALPHA, 24'd0),
			reg_row(REG_BETA, 24'hFF_FFFF),
			item(KIND_SAMPLE, 10'd500, 12'd77, 6'd0, 32'h1234_5678, 1'b1, 6'd3),
			// zero divisor on empty topics
			reg_row(REG_ALPHA, 24'hFF_FFFF),
			reg_row(REG_BETA, 24'd0),
			reg_row(REG_VOCAB, 24'd0),
			item(KIND_SAMPLE, 10'd0, 12'd0, 6'd0, 32'hC000_0000, 1'b0, 6'd0),
			// topic count zero acts as one
			reg_row(REG_TOPICS, 24'd0),
			item(KIND_SAMPLE, 10'd9, 12'd9, 6'd2, 32'hFFFF_FFFF, 1'b1, 6'd0),
			// topic count above the table acts as the full table
			reg_row(REG_TOPICS, 24'd127),
			reg_row(REG_VOCAB, 24'd8191),
			reg_row(REG_BETA, 24'hFF_FFFF),
			item(KIND_SAMPLE, 10'd1023, 12'd4095, 6'd0, 32'h7FFF_FFFF, 1'b0, 6'd0),
			reg_row(REG_TOPICS, 24'd1),
			item(KIND_SAMPLE, 10'd0, 12'd0, 6'd0, 32'h0000_0001, 1'b1, 6'd0)
		};
		foreach (dir_tab[i]) begin
			if (dir_tab[i].rk == ROW_CFG)
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			else
				send_word(dir_tab[i].kind, dir_tab[i].doc, dir_tab[i].word, dir_tab[i].old,
					dir_tab[i].u, dir_tab[i].typed, dir_tab[i].topic, -1);
		end

		// random phases: load a token pool, then resample it with some noise mixed in
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(3))
				0: write_reg(REG_ALPHA, 24'd655);
				1: write_reg(REG_ALPHA, 24'hFF_FFFF);
				2: write_reg(REG_ALPHA, 24'd0);
				default: write_reg(REG_ALPHA, 24'($urandom));
			endcase
			case ($urandom_range(3))
				0: write_reg(REG_BETA, 24'd3277);
				1: write_reg(REG_BETA, 24'($urandom_range(65535)));
				2: write_reg(REG_BETA, 24'd0);
				default: write_reg(REG_BETA, 24'($urandom));
			endcase
			write_reg(REG_VOCAB, ($urandom_range(3) == 0) ? 24'($urandom_range(8191)) :
				24'($urandom_range(4096, 1)));
			// one phase runs the full topic table, briefly, since it is slow
			if (ph == 5) begin
				write_reg(REG_TOPICS, 24'd64);
				nsamp = 8;
			end else begin
				write_reg(REG_TOPICS, 24'($urandom_range(8, 2)));
				nsamp = 150;
			end
			for (int p = 0; p < POOL; p++) begin
				pool_doc[p] = ($urandom_range(5) == 0) ? 10'($urandom) : 10'($urandom_range(3));
				pool_word[p] = ($urandom_range(5) == 0) ? 12'($urandom) : 12'($urandom_range(5));
				send_word(KIND_LOAD, pool_doc[p], pool_word[p],
					($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(sh_topics - 1)),
					$urandom, 1'b0, 6'd0, p);
			end
			for (int n = 0; n < nsamp; n++) begin
				if ($urandom_range(99) < 85) begin
					s = $urandom_range(POOL - 1);
					send_word(KIND_SAMPLE, pool_doc[s], pool_word[s], pool_topic[s], $urandom,
						1'b0, 6'd0, s);
				end else
					send_word(1'($urandom), 10'($urandom), 12'($urandom), 6'($urandom),
						$urandom, 1'b0, 6'd0, -1);
			end
		end

		start <= 1'b0;
		while (topic_exp_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
